FILE: hw/rtl/tcw_pkg.sv
// tcw_pkg: shared constants, command codes and state type for the text console writer
// used by tcw_cell_mem, tcw_ctrl, text_console_writer and tcw_checker
package tcw_pkg;

    localparam int DEFAULT_COLUMNS = 80;
    localparam int DEFAULT_ROWS    = 25;

    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int CELL_W  = 16;
    localparam int INDEX_W = 11;
    localparam int POS_W   = 11;

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0F20;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FILL,
        ST_RESULT
    } tcw_state_t;

endpackage

FILE: hw/rtl/tcw_cell_mem.sv
// tcw_cell_mem: screen cell store, one write port and one registered read port
// depends on tcw_pkg for the cell width and the default depth
module tcw_cell_mem #(
    parameter int DEPTH = tcw_pkg::DEFAULT_COLUMNS * tcw_pkg::DEFAULT_ROWS,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [tcw_pkg::CELL_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [tcw_pkg::CELL_W-1:0]  rd_data
);

    logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];
    logic [tcw_pkg::CELL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/tcw_ctrl.sv
// tcw_ctrl: command sequencer, cursor registers and read-modify-write of the cell store
// depends on tcw_pkg; drives the ports of tcw_cell_mem
module tcw_ctrl #(
    parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEFAULT_ROWS,
    localparam int CELLS  = COLUMNS * ROWS,
    localparam int AW     = $clog2(CELLS)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [tcw_pkg::CMD_W-1:0]   command,
    input  logic [tcw_pkg::BYTE_W-1:0]  char_code,
    input  logic [tcw_pkg::BYTE_W-1:0]  color,
    input  logic [tcw_pkg::INDEX_W-1:0] cell_index,
    input  logic                        out_busy,
    output logic                        res_load,
    output logic [tcw_pkg::POS_W-1:0]   res_pos,
    output logic [tcw_pkg::CELL_W-1:0]  res_data,
    output logic                        mem_wr_en,
    output logic [AW-1:0]               mem_wr_addr,
    output logic [tcw_pkg::CELL_W-1:0]  mem_wr_data,
    output logic                        mem_rd_en,
    output logic [AW-1:0]               mem_rd_addr,
    input  logic [tcw_pkg::CELL_W-1:0]  mem_rd_data
);

    localparam int CW   = $clog2(COLUMNS);
    localparam int RW   = $clog2(ROWS);
    localparam int MOVE = (ROWS - 1) * COLUMNS;
    localparam int WIDE = (AW > tcw_pkg::INDEX_W) ? AW : tcw_pkg::INDEX_W;

    tcw_pkg::tcw_state_t state_reg, state_next;
    logic [AW-1:0]              cnt_reg, cnt_next;
    logic [CW-1:0]              col_reg, col_next;
    logic [RW-1:0]              row_reg, row_next;
    logic [tcw_pkg::CELL_W-1:0] data_reg, data_next;

    logic [AW-1:0]   cur_lin;
    logic [WIDE-1:0] lin_wide;
    logic [WIDE-1:0] index_wide;
    logic            index_ok;
    logic            col_last;
    logic            row_last;

    assign cur_lin    = AW'(row_reg) * AW'(COLUMNS) + AW'(col_reg);
    assign lin_wide   = WIDE'(cur_lin);
    assign index_wide = WIDE'(cell_index);
    assign index_ok   = {1'b0, index_wide} < (WIDE + 1)'(CELLS);
    assign col_last   = col_reg == CW'(COLUMNS - 1);
    assign row_last   = row_reg == RW'(ROWS - 1);
    assign res_pos    = lin_wide[tcw_pkg::POS_W-1:0];
    assign res_data   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcw_pkg::ST_INIT;
            cnt_reg   <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        data_next   = data_reg;
        in_stall    = 1'b1;
        res_load    = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = cnt_reg;
        mem_wr_data = tcw_pkg::BLANK_CELL;
        mem_rd_en   = 1'b0;
        mem_rd_addr = cnt_reg;

        case (state_reg)
            tcw_pkg::ST_INIT:
            begin
                mem_wr_en = 1'b1;
                if (cnt_reg == AW'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = tcw_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end

            tcw_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    data_next  = '0;
                    state_next = tcw_pkg::ST_RESULT;
                    case (command)
                        tcw_pkg::CMD_PUT:
                        begin
                            if (char_code != tcw_pkg::NEWLINE_BYTE)
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = cur_lin;
                                mem_wr_data = {color, char_code};
                            end
                            if (char_code == tcw_pkg::NEWLINE_BYTE || col_last)
                            begin
                                col_next = '0;
                                if (row_last)
                                begin
                                    cnt_next   = '0;
                                    state_next = tcw_pkg::ST_SCROLL;
                                end
                                else
                                begin
                                    row_next = row_reg + RW'(1);
                                end
                            end
                            else
                            begin
                                col_next = col_reg + CW'(1);
                            end
                        end

                        tcw_pkg::CMD_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            cnt_next   = '0;
                            state_next = tcw_pkg::ST_FILL;
                        end

                        tcw_pkg::CMD_READ:
                        begin
                            if (index_ok)
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = index_wide[AW-1:0];
                                state_next  = tcw_pkg::ST_READ;
                            end
                        end

                        default:
                        begin
                            state_next = tcw_pkg::ST_RESULT;
                        end
                    endcase
                end
            end

            tcw_pkg::ST_READ:
            begin
                data_next  = mem_rd_data;
                state_next = tcw_pkg::ST_RESULT;
            end

            // row copy: read one row down, write back the cell read last cycle
            tcw_pkg::ST_SCROLL:
            begin
                if (cnt_reg != '0)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = cnt_reg - AW'(1);
                    mem_wr_data = mem_rd_data;
                end
                if (cnt_reg == AW'(MOVE))
                begin
                    state_next = tcw_pkg::ST_FILL;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = cnt_reg + AW'(COLUMNS);
                    cnt_next    = cnt_reg + AW'(1);
                end
            end

            tcw_pkg::ST_FILL:
            begin
                mem_wr_en = 1'b1;
                if (cnt_reg == AW'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = tcw_pkg::ST_RESULT;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end

            tcw_pkg::ST_RESULT:
            begin
                if (!out_busy)
                begin
                    res_load   = 1'b1;
                    state_next = tcw_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/text_console_writer.sv
// text_console_writer: top level of the text console engine with its output register
// depends on tcw_pkg, tcw_ctrl and tcw_cell_mem
//
// Text console of ROWS x COLUMNS 16-bit cells held in one synchronous memory, with a
// cursor; each transaction in gives exactly one transaction out carrying the cursor
// position and, for a read on the screen, the cell; a read beyond the screen gives a zero
// cell. One item is worked at a time. A clear sweeps the memory one cell a cycle. A put
// that scrolls copies the rows up through the single write port and blanks the bottom
// row. A finished result waits while the previous one is still held by out_stall. After
// reset a clearing pass blanks every cell before the first transaction is taken. The
// output register lets the next transaction in start while a result is still held.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [tcw_pkg::CMD_W-1:0]   command,
    input  logic [tcw_pkg::BYTE_W-1:0]  char_code,
    input  logic [tcw_pkg::BYTE_W-1:0]  color,
    input  logic [tcw_pkg::INDEX_W-1:0] cell_index,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [tcw_pkg::POS_W-1:0]   cursor_pos,
    output logic [tcw_pkg::CELL_W-1:0]  cell_data
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    logic                       res_load;
    logic [tcw_pkg::POS_W-1:0]  res_pos;
    logic [tcw_pkg::CELL_W-1:0] res_data;
    logic                       mem_wr_en;
    logic [AW-1:0]              mem_wr_addr;
    logic [tcw_pkg::CELL_W-1:0] mem_wr_data;
    logic                       mem_rd_en;
    logic [AW-1:0]              mem_rd_addr;
    logic [tcw_pkg::CELL_W-1:0] mem_rd_data;

    logic                       out_valid_reg;
    logic [tcw_pkg::POS_W-1:0]  cursor_pos_reg;
    logic [tcw_pkg::CELL_W-1:0] cell_data_reg;

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .char_code   (char_code),
        .color       (color),
        .cell_index  (cell_index),
        .out_busy    (out_valid_reg && out_stall),
        .res_load    (res_load),
        .res_pos     (res_pos),
        .res_data    (res_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    tcw_cell_mem #(
        .DEPTH (CELLS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            cursor_pos_reg <= res_pos;
            cell_data_reg  <= res_data;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cursor_pos = cursor_pos_reg;
    assign cell_data  = cell_data_reg;

endmodule

FILE: hw/rtl/tcw_checker.sv
// tcw_checker: port-level checks of the text console writer, bound to the top level
// depends on tcw_pkg and text_console_writer
module tcw_checker #(
    parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [tcw_pkg::POS_W-1:0]   cursor_pos,
    input logic [tcw_pkg::CELL_W-1:0]  cell_data
);

    localparam int CELLS = COLUMNS * ROWS;

    // held transaction out keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cursor_pos) && $stable(cell_data))
    else $error("held result changed");

    // a reported cursor position lies on the screen (checked while CELLS fits in 11 bits)
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (CELLS > 2047) || (32'(cursor_pos) < CELLS))
    else $error("cursor position beyond screen");

    // one transaction in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while busy");

    // a new result only appears after work that held off the input
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
    else $error("result without busy cycle");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cursor_pos (cursor_pos),
    .cell_data  (cell_data)
);
